// ===== design/dsfr_pkg.sv =====
`timescale 1ns / 1ps

package dsfr_pkg;

  // Default longest frame before the position counter parks
  localparam int MAX_FRAME_LEN_DEF = 64;

  // Register map (byte address = 4 * index)
  localparam int          REG_IDX_W          = 3;
  localparam int          PADDR_W            = 5;
  localparam logic [2:0]  REG_FRAME_HEADER   = 3'd0;
  localparam logic [2:0]  REG_LINK_TIMEOUT   = 3'd1;
  localparam logic [2:0]  REG_DATA_MAX       = 3'd2;
  localparam logic [2:0]  REG_ON_STATE       = 3'd3;
  localparam logic [2:0]  REG_ERROR_STATE    = 3'd4;
  localparam logic [2:0]  REG_OFF_STATE      = 3'd5;

  // Register reset values
  localparam logic [7:0]  FRAME_HEADER_RST   = 8'd22;
  localparam logic [7:0]  LINK_TIMEOUT_RST   = 8'd10;
  localparam logic [15:0] DATA_MAX_RST       = 16'd1000;
  localparam logic [7:0]  ON_STATE_RST       = 8'd2;
  localparam logic [7:0]  ERROR_STATE_RST    = 8'd255;
  localparam logic [7:0]  OFF_STATE_RST      = 8'd1;

  // Link countdown value after reset
  localparam logic [7:0]  LINK_RESET         = 8'd10;

  // Frame type bytes
  localparam logic [7:0]  TYPE_STATE_B1      = 8'h02;
  localparam logic [7:0]  TYPE_STATE_B2      = 8'h0C;
  localparam logic [7:0]  TYPE_DATA_B1       = 8'h11;
  localparam logic [7:0]  TYPE_DATA_B2       = 8'h0B;

  // Captured byte slots and the frame positions they hold
  localparam int NUM_CAPTURE = 10;
  localparam logic [3:0] SLOT_POS [NUM_CAPTURE] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd13, 4'd14
  };

  // Command request codes
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  frame_header;
    logic [7:0]  link_timeout;
    logic [15:0] data_max;
    logic [7:0]  on_state;
    logic [7:0]  error_state;
    logic [7:0]  off_state;
  } cfg_t;

  // Outcome of a byte word, from receiver to supervisor
  typedef struct packed {
    logic        accepted;
    logic        set_state;
    logic [7:0]  state_val;
    logic        load_readings;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [15:0] pm1;
  } frame_evt_t;

  // Values shown in a result word
  typedef struct packed {
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [15:0] pm1;
    logic [7:0]  state;
    cmd_t        cmd;
  } sup_view_t;

endpackage

// ===== design/dsfr_cfg.sv =====
`timescale 1ns / 1ps

module dsfr_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dsfr_pkg::cfg_t              cfg
);

  dsfr_pkg::cfg_t                 cfg_r;
  dsfr_pkg::cfg_t                 cfg_nxt;
  logic [dsfr_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;

  assign idx    = paddr[dsfr_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        dsfr_pkg::REG_FRAME_HEADER: cfg_nxt.frame_header = pwdata[7:0];
        dsfr_pkg::REG_LINK_TIMEOUT: cfg_nxt.link_timeout = pwdata[7:0];
        dsfr_pkg::REG_DATA_MAX:     cfg_nxt.data_max     = pwdata[15:0];
        dsfr_pkg::REG_ON_STATE:     cfg_nxt.on_state     = pwdata[7:0];
        dsfr_pkg::REG_ERROR_STATE:  cfg_nxt.error_state  = pwdata[7:0];
        dsfr_pkg::REG_OFF_STATE:    cfg_nxt.off_state    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_header <= dsfr_pkg::FRAME_HEADER_RST;
      cfg_r.link_timeout <= dsfr_pkg::LINK_TIMEOUT_RST;
      cfg_r.data_max     <= dsfr_pkg::DATA_MAX_RST;
      cfg_r.on_state     <= dsfr_pkg::ON_STATE_RST;
      cfg_r.error_state  <= dsfr_pkg::ERROR_STATE_RST;
      cfg_r.off_state    <= dsfr_pkg::OFF_STATE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      dsfr_pkg::REG_FRAME_HEADER: prdata = {24'd0, cfg_r.frame_header};
      dsfr_pkg::REG_LINK_TIMEOUT: prdata = {24'd0, cfg_r.link_timeout};
      dsfr_pkg::REG_DATA_MAX:     prdata = {16'd0, cfg_r.data_max};
      dsfr_pkg::REG_ON_STATE:     prdata = {24'd0, cfg_r.on_state};
      dsfr_pkg::REG_ERROR_STATE:  prdata = {24'd0, cfg_r.error_state};
      dsfr_pkg::REG_OFF_STATE:    prdata = {24'd0, cfg_r.off_state};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/dsfr_rx.sv =====
`timescale 1ns / 1ps

module dsfr_rx #(
  parameter int MAX_FRAME_LEN = dsfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,       // byte word advances this cycle
  input  logic [7:0]             rx_byte,
  input  logic                   frame_end,
  input  dsfr_pkg::cfg_t         cfg,
  output dsfr_pkg::frame_evt_t   evt
);

  localparam int POS_W = $clog2(MAX_FRAME_LEN + 1);

  logic [7:0]       sum_r, sum_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       cap_r   [dsfr_pkg::NUM_CAPTURE];
  logic [7:0]       cap_nxt [dsfr_pkg::NUM_CAPTURE];
  logic [7:0]       view    [dsfr_pkg::NUM_CAPTURE];
  logic [dsfr_pkg::NUM_CAPTURE-1:0] hit;
  logic [7:0]       expect_sum;
  logic             good;
  logic [15:0]      w25, w10, w1;

  // Slot hits at the current position; the current byte is seen by the check
  always_comb begin
    for (int k = 0; k < dsfr_pkg::NUM_CAPTURE; k++) begin
      hit[k]     = (pos_r == POS_W'(dsfr_pkg::SLOT_POS[k]));
      view[k]    = hit[k] ? rx_byte : cap_r[k];
      cap_nxt[k] = (step && hit[k]) ? rx_byte : cap_r[k];
    end
  end

  // Checksum and frame decisions
  assign expect_sum = 8'd0 - sum_r;
  assign good       = frame_end && (view[0] == cfg.frame_header) && (rx_byte == expect_sum);
  assign w25        = {view[4], view[5]};
  assign w10        = {view[6], view[7]};
  assign w1         = {view[8], view[9]};

  always_comb begin
    evt.accepted      = good;
    evt.set_state     = good && (view[1] == dsfr_pkg::TYPE_STATE_B1)
                             && (view[2] == dsfr_pkg::TYPE_STATE_B2);
    evt.state_val     = view[3];
    evt.load_readings = good && (view[1] == dsfr_pkg::TYPE_DATA_B1)
                             && (view[2] == dsfr_pkg::TYPE_DATA_B2);
    evt.pm25          = (w25 > cfg.data_max) ? cfg.data_max : w25;
    evt.pm10          = (w10 > cfg.data_max) ? cfg.data_max : w10;
    evt.pm1           = (w1  > cfg.data_max) ? cfg.data_max : w1;
  end

  // Running sum and position
  always_comb begin
    sum_nxt = sum_r;
    pos_nxt = pos_r;
    if (step) begin
      if (frame_end) begin
        sum_nxt = 8'd0;
        pos_nxt = '0;
      end else begin
        sum_nxt = sum_r + rx_byte;
        if (pos_r < POS_W'(MAX_FRAME_LEN)) pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 8'd0;
      pos_r <= '0;
      for (int k = 0; k < dsfr_pkg::NUM_CAPTURE; k++) cap_r[k] <= 8'd0;
    end else begin
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      for (int k = 0; k < dsfr_pkg::NUM_CAPTURE; k++) cap_r[k] <= cap_nxt[k];
    end
  end

endmodule

// ===== design/dsfr_sup.sv =====
`timescale 1ns / 1ps

module dsfr_sup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_step,   // byte word advances
  input  logic                 tick_step,   // tick word with sensing on advances
  input  dsfr_pkg::frame_evt_t evt,
  input  dsfr_pkg::cfg_t       cfg,
  output dsfr_pkg::sup_view_t  view_nxt     // values after this word
);

  logic [7:0]  cd_r,    cd_nxt;
  logic [7:0]  state_r, state_nxt;
  logic [15:0] pm25_r,  pm25_nxt;
  logic [15:0] pm10_r,  pm10_nxt;
  logic [15:0] pm1_r,   pm1_nxt;

  // Frame results and link supervision
  always_comb begin
    cd_nxt    = cd_r;
    state_nxt = state_r;
    pm25_nxt  = pm25_r;
    pm10_nxt  = pm10_r;
    pm1_nxt   = pm1_r;
    if (byte_step && evt.accepted) begin
      cd_nxt = cfg.link_timeout;
      if (evt.set_state) state_nxt = evt.state_val;
      if (evt.load_readings) begin
        pm25_nxt = evt.pm25;
        pm10_nxt = evt.pm10;
        pm1_nxt  = evt.pm1;
      end
    end else if (tick_step) begin
      if (cd_r != 8'd0) cd_nxt = cd_r - 8'd1;
      else              state_nxt = cfg.error_state;
    end
  end

  always_comb begin
    view_nxt.pm25  = pm25_nxt;
    view_nxt.pm10  = pm10_nxt;
    view_nxt.pm1   = pm1_nxt;
    view_nxt.state = state_nxt;
    if (!tick_step)                       view_nxt.cmd = dsfr_pkg::CMD_NONE;
    else if (state_nxt == cfg.on_state)   view_nxt.cmd = dsfr_pkg::CMD_READ;
    else                                  view_nxt.cmd = dsfr_pkg::CMD_START;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r    <= dsfr_pkg::LINK_RESET;
      state_r <= dsfr_pkg::OFF_STATE_RST;
      pm25_r  <= 16'd0;
      pm10_r  <= 16'd0;
      pm1_r   <= 16'd0;
    end else begin
      cd_r    <= cd_nxt;
      state_r <= state_nxt;
      pm25_r  <= pm25_nxt;
      pm10_r  <= pm10_nxt;
      pm1_r   <= pm1_nxt;
    end
  end

endmodule

// ===== design/dust_sensor_frame_receiver.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+--------------------------------------------
// in_      | input     | in_valid/in_stall  | mode, rx_byte, frame_end, sense_enabled
// out_     | output    | out_valid/out_stall| pm25, pm10, pm1, sensor_state, cmd, accepted
// cfg (APB)| input     | psel/penable/pready| register writes and reads, 4-byte stride
//
// Each word is held in the input register until it advances; its result is then
// registered into the output register, where out_valid rises for it.
// One word per cycle unless stalled, set by the single compute pass between them.
// Synchronous active-low reset clears both pipeline valids and loads defaults.
// A stalled result holds the output register; the input register still takes
// one word, then in_stall rises until the result is taken.

module dust_sensor_frame_receiver #(
  parameter int MAX_FRAME_LEN = dsfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [7:0]                   in_rx_byte,
  input  logic                         in_frame_end,
  input  logic                         in_sense_enabled,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_pm25_value,
  output logic [15:0]                  out_pm10_value,
  output logic [15:0]                  out_pm1_value,
  output logic [7:0]                   out_sensor_state,
  output logic [1:0]                   out_command_request,
  output logic                         out_frame_accepted,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  dsfr_pkg::cfg_t       cfg;
  dsfr_pkg::frame_evt_t evt;
  dsfr_pkg::sup_view_t  view_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_mode_r, s1_fend_r, s1_sense_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_pm25_r, out_pm10_r, out_pm1_r;
  logic [7:0]  out_state_r;
  logic [1:0]  out_cmd_r;
  logic        out_acc_r;
  logic        in_take, adv, byte_step, tick_step;

  // Pipeline handshake
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign byte_step = adv && !s1_mode_r;
  assign tick_step = adv && s1_mode_r && s1_sense_r;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  dsfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsfr_rx #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (byte_step),
    .rx_byte   (s1_byte_r),
    .frame_end (s1_fend_r),
    .cfg       (cfg),
    .evt       (evt)
  );

  dsfr_sup u_sup (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_step (byte_step),
    .tick_step (tick_step),
    .evt       (evt),
    .cfg       (cfg),
    .view_nxt  (view_nxt)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_mode;
      s1_byte_r  <= in_rx_byte;
      s1_fend_r  <= in_frame_end;
      s1_sense_r <= in_sense_enabled;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pm25_r  <= view_nxt.pm25;
      out_pm10_r  <= view_nxt.pm10;
      out_pm1_r   <= view_nxt.pm1;
      out_state_r <= view_nxt.state;
      out_cmd_r   <= view_nxt.cmd;
      out_acc_r   <= byte_step && evt.accepted;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pm25_value      = out_pm25_r;
  assign out_pm10_value      = out_pm10_r;
  assign out_pm1_value       = out_pm1_r;
  assign out_sensor_state    = out_state_r;
  assign out_command_request = out_cmd_r;
  assign out_frame_accepted  = out_acc_r;

`ifndef SYNTHESIS
  // Accepted frame only ever comes from a byte word, never with a command
  a_acc_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_accepted |-> out_command_request == dsfr_pkg::CMD_NONE)
    else $error("frame accepted together with a command request");

  // Input side only stalls when the input register is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // A word leaving the input register shows up as a result next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced word did not reach the output register");

  // Reset empties both stages
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  // Command code stays within its defined values
  a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command_request == dsfr_pkg::CMD_NONE ||
                   out_command_request == dsfr_pkg::CMD_READ ||
                   out_command_request == dsfr_pkg::CMD_START))
    else $error("illegal command request code");
`endif

endmodule

// ===== verif/dsfr_frame_predict_check.sv =====
`timescale 1ns / 1ps

module dsfr_frame_predict_check (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_mode,
  input  logic [7:0]                    in_rx_byte,
  input  logic                          in_frame_end,
  input  logic                          in_sense_enabled,
  // result channel
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [15:0]                   out_pm25_value,
  input  logic [15:0]                   out_pm10_value,
  input  logic [15:0]                   out_pm1_value,
  input  logic [7:0]                    out_sensor_state,
  input  logic [1:0]                    out_command_request,
  input  logic                          out_frame_accepted,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [dsfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  // counters for the top
  output int                            mismatch_count,
  output int                            words_in_flight,
  output int                            frames_taken,
  output int                            command_ticks
);

  // One predicted result word
  typedef struct packed {
    logic [15:0]    pm25;
    logic [15:0]    pm10;
    logic [15:0]    pm1;
    logic [7:0]     state;
    dsfr_pkg::cmd_t cmd;
    logic           accepted;
  } reading_word_t;

  reading_word_t expected_words[$];
  reading_word_t want_w;

  // Receiver copy: configuration and state
  dsfr_pkg::cfg_t cfg_shadow;
  logic [7:0]     frame_sum;
  logic [6:0]     frame_pos;
  logic [7:0]     captured [dsfr_pkg::NUM_CAPTURE];
  logic [7:0]     link_left;
  logic [7:0]     state_now;
  logic [15:0]    readings [3];

  // Capture slot for a frame position, -1 when not captured
  function automatic int slot_for(logic [6:0] pos);
    for (int s = 0; s < dsfr_pkg::NUM_CAPTURE; s++) begin
      if (pos == 7'(dsfr_pkg::SLOT_POS[s])) return s;
    end
    return -1;
  endfunction

  // Big-endian reading from two captured bytes, clamped at data_max
  function automatic logic [15:0] clamp_reading(int hi, int lo);
    logic [15:0] raw;
    raw = {captured[hi], captured[lo]};
    return (raw > cfg_shadow.data_max) ? cfg_shadow.data_max : raw;
  endfunction

  // Advance the receiver by one input word and return its result
  function automatic reading_word_t predict_word(logic mode, logic [7:0] rx,
                                                 logic fend, logic sense);
    reading_word_t w;
    int slot;
    logic [7:0] want_csum;
    w.cmd = dsfr_pkg::CMD_NONE;
    w.accepted = 1'b0;
    if (!mode) begin
      slot = slot_for(frame_pos);
      if (slot >= 0) captured[slot] = rx;
      if (fend) begin
        want_csum = 8'd0 - frame_sum;
        if (captured[0] == cfg_shadow.frame_header && rx == want_csum) begin
          w.accepted = 1'b1;
          link_left = cfg_shadow.link_timeout;
          if (captured[1] == dsfr_pkg::TYPE_STATE_B1 &&
              captured[2] == dsfr_pkg::TYPE_STATE_B2) begin
            state_now = captured[3];
          end else if (captured[1] == dsfr_pkg::TYPE_DATA_B1 &&
                       captured[2] == dsfr_pkg::TYPE_DATA_B2) begin
            readings[0] = clamp_reading(4, 5);
            readings[1] = clamp_reading(6, 7);
            readings[2] = clamp_reading(8, 9);
          end
        end
        frame_sum = '0;
        frame_pos = '0;
      end else begin
        frame_sum = frame_sum + rx;
        if (frame_pos < dsfr_pkg::MAX_FRAME_LEN_DEF) frame_pos = frame_pos + 7'd1;
      end
    end else if (sense) begin
      // link supervision on a one-second tick
      if (link_left != 8'd0) link_left = link_left - 8'd1;
      else state_now = cfg_shadow.error_state;
      w.cmd = (state_now == cfg_shadow.on_state) ? dsfr_pkg::CMD_READ : dsfr_pkg::CMD_START;
    end
    w.pm25 = readings[0];
    w.pm10 = readings[1];
    w.pm1 = readings[2];
    w.state = state_now;
    return w;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_shadow.frame_header = dsfr_pkg::FRAME_HEADER_RST;
      cfg_shadow.link_timeout = dsfr_pkg::LINK_TIMEOUT_RST;
      cfg_shadow.data_max = dsfr_pkg::DATA_MAX_RST;
      cfg_shadow.on_state = dsfr_pkg::ON_STATE_RST;
      cfg_shadow.error_state = dsfr_pkg::ERROR_STATE_RST;
      cfg_shadow.off_state = dsfr_pkg::OFF_STATE_RST;
      frame_sum = '0;
      frame_pos = '0;
      foreach (captured[i]) captured[i] = '0;
      link_left = dsfr_pkg::LINK_RESET;
      state_now = dsfr_pkg::OFF_STATE_RST;
      foreach (readings[i]) readings[i] = '0;
      expected_words.delete();
    end else begin
      // register writes land in the shadow copy
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          dsfr_pkg::REG_FRAME_HEADER: cfg_shadow.frame_header = pwdata[7:0];
          dsfr_pkg::REG_LINK_TIMEOUT: cfg_shadow.link_timeout = pwdata[7:0];
          dsfr_pkg::REG_DATA_MAX:     cfg_shadow.data_max = pwdata[15:0];
          dsfr_pkg::REG_ON_STATE:     cfg_shadow.on_state = pwdata[7:0];
          dsfr_pkg::REG_ERROR_STATE:  cfg_shadow.error_state = pwdata[7:0];
          dsfr_pkg::REG_OFF_STATE:    cfg_shadow.off_state = pwdata[7:0];
          default: ;
        endcase
      end
      // accepted input word: predict and queue
      if (in_valid && !in_stall) begin
        want_w = predict_word(in_mode, in_rx_byte, in_frame_end, in_sense_enabled);
        expected_words.push_back(want_w);
        if (want_w.accepted) frames_taken++;
        if (want_w.cmd != dsfr_pkg::CMD_NONE) command_ticks++;
      end
      // accepted result word: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatch_count++;
        end else begin
          want_w = expected_words.pop_front();
          check_field("pm25_value", want_w.pm25, out_pm25_value);
          check_field("pm10_value", want_w.pm10, out_pm10_value);
          check_field("pm1_value", want_w.pm1, out_pm1_value);
          check_field("sensor_state", want_w.state, out_sensor_state);
          check_field("command_request", int'(want_w.cmd), out_command_request);
          check_field("frame_accepted", want_w.accepted, out_frame_accepted);
        end
      end
    end
    words_in_flight = expected_words.size();
  end

endmodule

// ===== verif/tb_dust_sensor_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_dust_sensor_frame_receiver;

  localparam int CYCLE_LIMIT = 250000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_mode;
  logic [7:0]                    in_rx_byte;
  logic                          in_frame_end;
  logic                          in_sense_enabled;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [15:0]                   out_pm25_value;
  logic [15:0]                   out_pm10_value;
  logic [15:0]                   out_pm1_value;
  logic [7:0]                    out_sensor_state;
  logic [1:0]                    out_command_request;
  logic                          out_frame_accepted;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dsfr_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int mismatch_count;
  int words_in_flight;
  int frames_taken;
  int command_ticks;
  int words_sent = 0;
  int cycles = 0;
  logic calm = 1'b0;

  // Settings currently loaded, for building good frames
  logic [7:0] hdr_now;
  logic [7:0] on_now;
  logic [7:0] err_now;
  logic [7:0] off_now;

  logic [7:0] frame_bytes[$];

  dust_sensor_frame_receiver dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_rx_byte          (in_rx_byte),
    .in_frame_end        (in_frame_end),
    .in_sense_enabled    (in_sense_enabled),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pm25_value      (out_pm25_value),
    .out_pm10_value      (out_pm10_value),
    .out_pm1_value       (out_pm1_value),
    .out_sensor_state    (out_sensor_state),
    .out_command_request (out_command_request),
    .out_frame_accepted  (out_frame_accepted),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  dsfr_frame_predict_check u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_rx_byte          (in_rx_byte),
    .in_frame_end        (in_frame_end),
    .in_sense_enabled    (in_sense_enabled),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pm25_value      (out_pm25_value),
    .out_pm10_value      (out_pm10_value),
    .out_pm1_value       (out_pm1_value),
    .out_sensor_state    (out_sensor_state),
    .out_command_request (out_command_request),
    .out_frame_accepted  (out_frame_accepted),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .pready              (pready),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .mismatch_count      (mismatch_count),
    .words_in_flight     (words_in_flight),
    .frames_taken        (frames_taken),
    .command_ticks       (command_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result-side backpressure, about 9 percent of the time
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One word on the input channel, with an occasional gap before it
  task automatic push_word(logic mode, logic [7:0] rx, logic fend, logic sense);
    if (!calm && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_rx_byte <= rx;
    in_frame_end <= fend;
    in_sense_enabled <= sense;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // tick words carry random junk in the ignored fields
  task automatic push_tick(logic sense);
    push_word(1'b1, 8'($urandom), 1'($urandom), sense);
  endtask

  // Frame of n random bytes with header and type in place
  task automatic start_frame(int n, logic [7:0] t1, logic [7:0] t2);
    frame_bytes.delete();
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
    frame_bytes[0] = hdr_now;
    if (n > 1) frame_bytes[1] = t1;
    if (n > 2) frame_bytes[2] = t2;
  endtask

  // last byte becomes the two's complement of the earlier sum
  task automatic seal_frame();
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < frame_bytes.size() - 1; i++) acc = acc + frame_bytes[i];
    frame_bytes[frame_bytes.size() - 1] = 8'd0 - acc;
  endtask

  task automatic send_frame(bit mix_ticks);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (mix_ticks && i > 0 && $urandom_range(24) == 0) push_tick(1'b1);
      push_word(1'b0, frame_bytes[i], i == frame_bytes.size() - 1, 1'($urandom));
    end
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dsfr_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_settings(logic [7:0] hdr, logic [7:0] tmo, logic [15:0] dmax,
                               logic [7:0] on_c, logic [7:0] err_c, logic [7:0] off_c);
    write_reg(dsfr_pkg::REG_FRAME_HEADER, 32'(hdr));
    write_reg(dsfr_pkg::REG_LINK_TIMEOUT, 32'(tmo));
    write_reg(dsfr_pkg::REG_DATA_MAX, 32'(dmax));
    write_reg(dsfr_pkg::REG_ON_STATE, 32'(on_c));
    write_reg(dsfr_pkg::REG_ERROR_STATE, 32'(err_c));
    write_reg(dsfr_pkg::REG_OFF_STATE, 32'(off_c));
    hdr_now = hdr;
    on_now = on_c;
    err_now = err_c;
    off_now = off_c;
  endtask

  // Mostly well-formed frames with random content, plus ticks, noise and bad frames
  task automatic run_random(int count);
    int stop_at;
    int pick;
    int n;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // reading frame: short ones reuse old captures, long ones park the position
        n = ($urandom_range(9) == 0) ? $urandom_range(3, 15) : $urandom_range(16, 22);
        if ($urandom_range(29) == 0) n = $urandom_range(60, 80);
        start_frame(n, dsfr_pkg::TYPE_DATA_B1, dsfr_pkg::TYPE_DATA_B2);
        for (int p = 5; p <= 13; p += 4) begin
          if (p < n - 1 && $urandom_range(9) < 6) frame_bytes[p] = 8'($urandom_range(3));
        end
        seal_frame();
        send_frame(1'b1);
      end else if (pick < 55) begin
        // state frame
        n = $urandom_range(4, 9);
        start_frame(n, dsfr_pkg::TYPE_STATE_B1, dsfr_pkg::TYPE_STATE_B2);
        if (n > 4) begin
          case ($urandom_range(3))
            0: frame_bytes[3] = on_now;
            1: frame_bytes[3] = off_now;
            2: frame_bytes[3] = err_now;
            default: ;
          endcase
        end
        seal_frame();
        send_frame(1'b1);
      end else if (pick < 73) begin
        repeat ($urandom_range(1, 6)) push_tick($urandom_range(9) != 0);
      end else if (pick < 85) begin
        // one flipped bit breaks the header or the checksum
        n = $urandom_range(1, 18);
        start_frame(n,
                    ($urandom_range(1) != 0) ? dsfr_pkg::TYPE_DATA_B1 : dsfr_pkg::TYPE_STATE_B1,
                    ($urandom_range(1) != 0) ? dsfr_pkg::TYPE_DATA_B2 : dsfr_pkg::TYPE_STATE_B2);
        seal_frame();
        frame_bytes[$urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
        send_frame(1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 5)) begin
          push_word(1'b0, 8'($urandom), $urandom_range(3) == 0, 1'($urandom));
        end
      end else if (pick < 97) begin
        wait_drained();
      end else begin
        // good frame of another type or a bare one-byte frame
        n = $urandom_range(1, 20);
        start_frame(n, 8'($urandom), 8'($urandom));
        seal_frame();
        send_frame(1'b1);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= 1'b0;
    in_rx_byte <= '0;
    in_frame_end <= 1'b0;
    in_sense_enabled <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hdr_now = dsfr_pkg::FRAME_HEADER_RST;
    on_now = dsfr_pkg::ON_STATE_RST;
    err_now = dsfr_pkg::ERROR_STATE_RST;
    off_now = dsfr_pkg::OFF_STATE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ticks off and on, lone header byte, state frame, saturated readings
    push_tick(1'b0);
    push_tick(1'b1);
    push_word(1'b0, hdr_now, 1'b1, 1'b0);
    start_frame(5, dsfr_pkg::TYPE_STATE_B1, dsfr_pkg::TYPE_STATE_B2);
    frame_bytes[3] = on_now;
    seal_frame();
    send_frame(1'b0);
    push_tick(1'b1);
    start_frame(16, dsfr_pkg::TYPE_DATA_B1, dsfr_pkg::TYPE_DATA_B2);
    for (int i = 3; i < 15; i++) frame_bytes[i] = 8'hFF;
    seal_frame();
    send_frame(1'b0);
    run_random(280);

    // all settings at zero: immediate expiry, zero ceiling, zero-byte frame accepted
    wait_drained();
    load_settings(8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    push_word(1'b0, 8'h00, 1'b1, 1'b0);
    push_tick(1'b1);
    run_random(200);

    // all settings at their maximum, no idling on either side
    wait_drained();
    calm = 1'b1;
    load_settings(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(250);
    wait_drained();
    calm = 1'b0;

    // random settings with a short link timeout
    load_settings(8'($urandom), 8'($urandom_range(1, 5)), 16'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    run_random(250);

    // defaults with a two-second link timeout
    wait_drained();
    load_settings(dsfr_pkg::FRAME_HEADER_RST, 8'd2, dsfr_pkg::DATA_MAX_RST,
                  dsfr_pkg::ON_STATE_RST, dsfr_pkg::ERROR_STATE_RST,
                  dsfr_pkg::OFF_STATE_RST);
    run_random(150);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d words over five register settings: %0d frames accepted,",
             words_sent, frames_taken);
    $display("%0d ticks asking for a command, random gaps and backpressure on both sides.",
             command_ticks);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
